// ----- sv/sfts_pkg.sv -----
// sfts_pkg: shared types and constants for the split frame transmit sequencer
// request codes, register indexes, reset values and the per-transfer result flags
// no dependencies
package sfts_pkg;

   localparam int SFTS_FRAME_BYTES = 9;

   localparam logic [7:0] GAP_TICKS_RESET   = 8'd4;
   localparam logic [3:0] SPLIT_POINT_RESET = 4'd7;

   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_DONE = 2'd2;

   localparam logic CSR_GAP_TICKS   = 1'b0;
   localparam logic CSR_SPLIT_POINT = 1'b1;

   typedef struct packed {
      logic tx_valid;
      logic seg_busy;
      logic push_dropped;
   } sfts_result_type;

endpackage

// ----- sv/sfts_ram.sv -----
// sfts_ram: generic single-port-write, single-port-read ram with registered read
// read data updates only when a read is enabled; no dependencies
module sfts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sfts_csr.sv -----
// sfts_csr: apb-style register file for gap_ticks and split_point
// depends on sfts_pkg for reset values and register indexes
module sfts_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  gap_ticks,
   output logic [3:0]  split_point
);
   import sfts_pkg::*;

   logic [7:0] gap_ticks_ff;
   logic [7:0] gap_ticks_in;
   logic [3:0] split_point_ff;
   logic [3:0] split_point_in;
   logic       wr_fire;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite;

   always_comb begin
      gap_ticks_in   = gap_ticks_ff;
      split_point_in = split_point_ff;
      if (wr_fire) begin
         case (paddr[2])
            CSR_GAP_TICKS:   gap_ticks_in   = pwdata[7:0];
            CSR_SPLIT_POINT: split_point_in = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff   <= GAP_TICKS_RESET;
         split_point_ff <= SPLIT_POINT_RESET;
      end else begin
         gap_ticks_ff   <= gap_ticks_in;
         split_point_ff <= split_point_in;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_GAP_TICKS:   prdata = {24'd0, gap_ticks_ff};
         CSR_SPLIT_POINT: prdata = {28'd0, split_point_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign gap_ticks   = gap_ticks_ff;
   assign split_point = split_point_ff;

endmodule

// ----- sv/sfts_ctrl.sv -----
// sfts_ctrl: pointer, fill and gap bookkeeping; issues frame buffer reads and writes
// depends on sfts_pkg for request codes and the result struct
module sfts_ctrl #(
   parameter int FRAME_BYTES = sfts_pkg::SFTS_FRAME_BYTES,
   parameter int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_accept,
   input  logic [1:0]               req_type,
   input  logic [7:0]               req_data_byte,
   input  logic [3:0]               req_push_len,
   input  logic                     req_push_first,
   input  logic                     req_push_last,
   input  logic [7:0]               gap_ticks,
   input  logic [3:0]               split_point,
   output logic                     mem_wr_en,
   output logic [AW-1:0]            mem_wr_addr,
   output logic [7:0]               mem_wr_data,
   output logic                     mem_rd_en,
   output logic [AW-1:0]            mem_rd_addr,
   output sfts_pkg::sfts_result_type result
);
   import sfts_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int SW = ((CW > 4) ? CW : 4) + 1;
   localparam logic [CW-1:0] LAST_CNT = CW'(FRAME_BYTES);

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          accepting_ff, accepting_in;
   logic          seg_done_ff, seg_done_in;
   logic [8:0]    gap_count_ff, gap_count_in;

   logic          acc_start;
   logic [CW-1:0] wp_start;
   logic [CW-1:0] rd_ptr_inc;
   logic          at_split;
   logic          inc_at_split;
   logic          has_bytes;

   always_comb begin
      acc_start    = req_push_first ?
                     ((SW'(fill_ff) + SW'(req_push_len)) <= SW'(FRAME_BYTES)) : accepting_ff;
      wp_start     = req_push_first ? fill_ff : wr_ptr_ff;
      rd_ptr_inc   = rd_ptr_ff + CW'(1);
      at_split     = (SW'(rd_ptr_ff) == SW'(split_point));
      inc_at_split = (SW'(rd_ptr_inc) == SW'(split_point));
      has_bytes    = fill_ff > rd_ptr_ff;
   end

   always_comb begin
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      accepting_in = accepting_ff;
      seg_done_in  = seg_done_ff;
      gap_count_in = gap_count_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wp_start[AW-1:0];
      mem_wr_data  = req_data_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_ptr_ff[AW-1:0];
      result.tx_valid     = 1'b0;
      result.push_dropped = 1'b0;
      if (item_accept) begin
         case (req_type)
            REQ_PUSH: begin
               accepting_in = acc_start;
               wr_ptr_in    = wp_start;
               if (acc_start && (wp_start < LAST_CNT)) begin
                  mem_wr_en = 1'b1;
                  wr_ptr_in = wp_start + CW'(1);
               end else begin
                  result.push_dropped = 1'b1;
               end
               // last byte commits what was actually written
               if (req_push_last) begin
                  if (acc_start) begin
                     fill_in = wr_ptr_in;
                  end
                  accepting_in = 1'b0;
               end
            end
            REQ_POLL: begin
               if (seg_done_ff && (gap_count_ff <= {1'b0, gap_ticks})) begin
                  gap_count_in = gap_count_ff + 9'd1;
               end else if (has_bytes && ((rd_ptr_ff == '0) || at_split)) begin
                  gap_count_in    = 9'd0;
                  seg_done_in     = 1'b0;
                  result.tx_valid = 1'b1;
                  mem_rd_en       = 1'b1;
                  rd_ptr_in       = rd_ptr_inc;
               end
            end
            REQ_DONE: begin
               if (has_bytes && !seg_done_ff) begin
                  result.tx_valid = 1'b1;
                  mem_rd_en       = 1'b1;
                  rd_ptr_in       = rd_ptr_inc;
                  if (rd_ptr_inc == LAST_CNT) begin
                     fill_in     = '0;
                     rd_ptr_in   = '0;
                     seg_done_in = 1'b1;
                  end else if (inc_at_split) begin
                     seg_done_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      result.seg_busy = !seg_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         accepting_ff <= 1'b0;
         seg_done_ff  <= 1'b1;
         gap_count_ff <= 9'd0;
      end else begin
         fill_ff      <= fill_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         accepting_ff <= accepting_in;
         seg_done_ff  <= seg_done_in;
         gap_count_ff <= gap_count_in;
      end
   end

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_CNT)
      else $error("fill level beyond frame size");

   a_read_behind_fill: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= fill_ff)
      else $error("read pointer ahead of fill level");

   a_no_read_and_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("buffer read and write in one transfer");

   // counting stops one past the largest gap_ticks, so the counter never wraps
   a_gap_saturates: assert property (@(posedge clock) disable iff (reset)
      gap_count_ff <= 9'd256)
      else $error("gap counter past its limit");

endmodule

// ----- sv/split_frame_tx_sequencer_unit.sv -----
// split_frame_tx_sequencer_unit: transmit sequencer for a split display frame
// usage: req_ channel takes push bytes, poll ticks and byte-done events; rsp_
// channel returns one result per request: tx byte (if any), segment busy and
// push-dropped flags. gap_ticks and split_point are set over the apb-style port.
// throughput: one request per cycle while req_stall is low. a request transfers
// at the edge where req_valid is high and req_stall is low; its result then moves
// through the buffer read stage and then the output register, where rsp_valid is high.
// the frame buffer sits in a ram with registered read; a request reads or writes
// it at most once and bookkeeping updates in the accept cycle, so back-to-back
// requests see each other's updates with no bubble.
// reset (synchronous) empties the frame, closes any open push, marks the segment
// done, clears the gap counter and loads gap_ticks 4 and split_point 7; buffer
// contents are not cleared and read as garbage until written.
// when rsp_stall holds, the output register keeps its result and one more
// request may still transfer into the read stage; after that req_stall rises.
// depends on sfts_pkg, sfts_ram, sfts_csr, sfts_ctrl
module split_frame_tx_sequencer_unit #(
   parameter int FRAME_BYTES = sfts_pkg::SFTS_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [3:0]  req_push_len,
   input  logic        req_push_first,
   input  logic        req_push_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_seg_busy,
   output logic        rsp_push_dropped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sfts_pkg::*;

   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   logic [7:0]      gap_ticks;
   logic [3:0]      split_point;
   logic            item_accept;
   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;
   sfts_result_type ctrl_result;

   logic            s1_valid_ff, s1_valid_in;
   sfts_result_type s1_res_ff, s1_res_in;
   logic            out_valid_ff, out_valid_in;
   sfts_result_type out_res_ff, out_res_in;
   logic [7:0]      out_byte_ff, out_byte_in;

   logic            out_free;
   logic            s1_move;
   logic            s1_free;

   sfts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .gap_ticks   (gap_ticks),
      .split_point (split_point)
   );

   sfts_ctrl #(
      .FRAME_BYTES (FRAME_BYTES),
      .AW          (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .item_accept    (item_accept),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_push_len   (req_push_len),
      .req_push_first (req_push_first),
      .req_push_last  (req_push_last),
      .gap_ticks      (gap_ticks),
      .split_point    (split_point),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .result         (ctrl_result)
   );

   sfts_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      out_free    = !out_valid_ff || !rsp_stall;
      s1_move     = s1_valid_ff && out_free;
      s1_free     = !s1_valid_ff || s1_move;
      req_stall   = !s1_free;
      item_accept = req_valid && s1_free;

      s1_valid_in  = item_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_res_in    = item_accept ? ctrl_result : s1_res_ff;
      out_valid_in = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
      out_res_in   = s1_move ? s1_res_ff : out_res_ff;
      // ram data stays put until the next read, so it is still this result's byte
      out_byte_in  = s1_move ? (s1_res_ff.tx_valid ? mem_rd_data : 8'd0) : out_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_res_ff   <= s1_res_in;
      out_res_ff  <= out_res_in;
      out_byte_ff <= out_byte_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tx_valid     = out_res_ff.tx_valid;
   assign rsp_tx_byte      = out_byte_ff;
   assign rsp_seg_busy     = out_res_ff.seg_busy;
   assign rsp_push_dropped = out_res_ff.push_dropped;

   a_stage_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |=> s1_valid_ff && $stable(s1_res_ff))
      else $error("read stage lost its result while output stalled");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'd0)
      else $error("tx byte nonzero without a transmit");

   a_push_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |-> !rsp_tx_valid)
      else $error("dropped push reported with a transmit byte");

endmodule
